[hdl/nqr_pkg.sv]
// ----------------------------------------------------------------------------
// nqr_pkg: shared types and constants of the quartic root finder
// Fixed-point format, beat payload structs, controller commands and the
// helper functions used by the datapath.
// ----------------------------------------------------------------------------
package nqr_pkg;

  // Fixed-point format of every value (Q8.24 by default).
  localparam int FRAC_BITS = 24;
  // Magnitude bits of a saturated wide intermediate value.
  localparam int MAG_W     = 62;
  // Dividend width of the bit-serial divider: magnitude shifted by FRAC_BITS.
  localparam int DIV_W     = MAG_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(DIV_W + 1);
  // Width of the saturated quotient: 33 integer bits plus the fraction.
  localparam int Q_W       = 33 + FRAC_BITS;

  localparam logic signed [63:0] WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [1:0] CFG_MIN_ITER  = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd2;

  typedef enum logic [1:0] {
    ST_CONVERGED    = 2'd0,
    ST_ZERO_DERIV   = 2'd1,
    ST_LEFT_INTERVAL = 2'd2,
    ST_ITER_CAP     = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] interval_low;
    logic signed [31:0] interval_high;
    logic signed [31:0] reference_root;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] root_estimate;
    logic [1:0]         status;
    logic [7:0]         iterations_done;
    logic [30:0]        final_error;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ERR,
    DP_DF_INIT,
    DP_F_INIT,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_MUL_FIN,
    DP_SAVE_DF,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_UPDATE,
    DP_OUT
  } dp_op_t;

  // Constant added after a Horner multiplication.
  typedef enum logic [1:0] {
    HC_P22,
    HC_P29,
    HC_P11,
    HC_M10
  } hcst_t;

  typedef struct packed {
    dp_op_t  op;
    hcst_t   cst_sel;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic loop_cond;
    logic cap_hit;
    logic zero_deriv;
    logic out_of_range;
    logic div_last;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_CHECK,
    S_DF_INIT,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_FIN,
    S_DERIV_CHK,
    S_F_INIT,
    S_DIV_INIT,
    S_DIV_STEP,
    S_UPDATE,
    S_FINISH
  } state_t;

  // Integer constant scaled to the fixed-point format.
  function automatic logic signed [63:0] cst_q(input int c);
    logic signed [63:0] v;
    v = 64'(c);
    return v <<< FRAC_BITS;
  endfunction

  // Saturate a 65-bit sum to +-WIDE_MAX.
  function automatic logic signed [63:0] clamp_wide(input logic signed [64:0] v);
    logic signed [64:0] lim;
    lim = 65'(WIDE_MAX);
    if (v > lim) begin
      return WIDE_MAX;
    end else if (v < -lim) begin
      return -WIDE_MAX;
    end
    return v[63:0];
  endfunction

  // Magnitude of a wide signed value.
  function automatic logic [63:0] mag_wide(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

[hdl/nqr_datapath.sv]
// ----------------------------------------------------------------------------
// nqr_datapath: arithmetic of the quartic root finder
// Holds the configuration registers, the iterate, the Horner accumulator
// with a two-pass 32x32 multiplier, a bit-serial divider and the result
// register.
// ----------------------------------------------------------------------------
module nqr_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_wdata,
  input  nqr_pkg::in_item_t in_data,
  input  nqr_pkg::dp_cmd_t  cmd,
  output nqr_pkg::dp_stat_t stat,
  output nqr_pkg::out_item_t out_data
);

  logic [30:0]        tol_r;
  logic [7:0]         min_r;
  logic [7:0]         max_r;

  logic signed [31:0] lo_r, hi_r, ref_r, x_r;
  logic [7:0]         k_r;
  logic [30:0]        err_r;
  logic signed [63:0] acc_r, dfx_r;
  logic [95:0]        prod_r;
  logic               msign_r;
  logic [nqr_pkg::MAG_W-1:0] ud_r, rem_r;
  logic [nqr_pkg::DIV_W-1:0] quo_r;
  logic [nqr_pkg::DCNT_W-1:0] cnt_r;
  logic               qneg_r;
  nqr_pkg::out_item_t out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 31'd17;
      min_r <= 8'd10;
      max_r <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nqr_pkg::CFG_TOLERANCE: tol_r <= cfg_wdata;
        nqr_pkg::CFG_MIN_ITER:  min_r <= cfg_wdata[7:0];
        nqr_pkg::CFG_MAX_ITER:  max_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Operand magnitudes and the shared multiplier, low half first.
  logic [63:0]        amag;
  logic [63:0]        dfmag;
  logic [31:0]        xmag;
  logic [31:0]        mul_a;
  logic [63:0]        mul_p;
  logic signed [63:0] x64;
  logic signed [32:0] sum_lh;

  assign amag    = nqr_pkg::mag_wide(acc_r);
  assign dfmag   = nqr_pkg::mag_wide(dfx_r);
  assign xmag    = x_r[31] ? 32'(-x_r) : 32'(x_r);
  assign mul_a   = (cmd.op == nqr_pkg::DP_MUL_HI) ? amag[63:32] : amag[31:0];
  assign mul_p   = mul_a * xmag;
  assign x64     = 64'(x_r);
  assign sum_lh  = 33'(in_data.interval_low) + 33'(in_data.interval_high);

  // Finishing a Horner step: truncate, saturate, sign, add constant.
  logic [95-nqr_pkg::FRAC_BITS:0] r_sh;
  logic [62:0]        rs;
  logic signed [64:0] prod_s, hc_val, fin_sum;

  assign r_sh = prod_r[95:nqr_pkg::FRAC_BITS];

  always_comb begin
    if (r_sh > (96 - nqr_pkg::FRAC_BITS)'(nqr_pkg::WIDE_MAX)) begin
      rs = 63'(nqr_pkg::WIDE_MAX);
    end else begin
      rs = r_sh[62:0];
    end
    prod_s = msign_r ? -$signed({2'b00, rs}) : $signed({2'b00, rs});
    unique case (cmd.cst_sel)
      nqr_pkg::HC_P22: hc_val = 65'(nqr_pkg::cst_q(22));
      nqr_pkg::HC_P29: hc_val = 65'(nqr_pkg::cst_q(29));
      nqr_pkg::HC_P11: hc_val = 65'(nqr_pkg::cst_q(11));
      nqr_pkg::HC_M10: hc_val = -65'(nqr_pkg::cst_q(10));
      default:         hc_val = '0;
    endcase
    fin_sum = prod_s + hc_val;
  end

  // Divider step: shift in one dividend bit and subtract when it fits.
  logic [nqr_pkg::MAG_W:0] rem_sh;
  logic                    q_bit;

  assign rem_sh = {rem_r, quo_r[nqr_pkg::DIV_W-1]};
  assign q_bit  = rem_sh >= {1'b0, ud_r};

  // Newton update with the saturated quotient.
  logic [nqr_pkg::MAG_W-1:0] qi;
  logic [32:0]               qsat;
  logic signed [nqr_pkg::Q_W+1:0] qs, xs;

  always_comb begin
    qi   = quo_r[nqr_pkg::DIV_W-1:nqr_pkg::FRAC_BITS];
    qsat = (qi > nqr_pkg::MAG_W'(34'h1_0000_0000)) ? 33'h1_0000_0000 : qi[32:0];
    qs   = $signed({2'b00, qsat, quo_r[nqr_pkg::FRAC_BITS-1:0]});
    xs   = $signed((nqr_pkg::Q_W + 2)'(x_r)) + (qneg_r ? qs : -qs);
  end

  // Distance of the iterate from the reference root, saturated.
  logic signed [32:0] dref;
  logic [32:0]        dmag;
  logic [30:0]        err_dist;

  assign dref     = 33'(x_r) - 33'(ref_r);
  assign dmag     = dref[32] ? 33'(-dref) : 33'(dref);
  assign err_dist = (dmag > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : dmag[30:0];

  // Main sequencing of the working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      nqr_pkg::DP_LOAD: begin
        lo_r  <= in_data.interval_low;
        hi_r  <= in_data.interval_high;
        ref_r <= in_data.reference_root;
        x_r   <= sum_lh[32:1];
        k_r   <= '0;
      end
      nqr_pkg::DP_ERR: begin
        err_r <= err_dist;
      end
      nqr_pkg::DP_DF_INIT: begin
        acc_r <= (x64 <<< 6) + (x64 <<< 4) + (x64 <<< 2) + nqr_pkg::cst_q(87);
      end
      nqr_pkg::DP_F_INIT: begin
        acc_r <= (x64 <<< 4) + (x64 <<< 2) + x64 + nqr_pkg::cst_q(29);
      end
      nqr_pkg::DP_MUL_LO: begin
        prod_r  <= 96'(mul_p);
        msign_r <= acc_r[63] ^ x_r[31];
      end
      nqr_pkg::DP_MUL_HI: begin
        prod_r <= prod_r + {mul_p, 32'd0};
      end
      nqr_pkg::DP_MUL_FIN: begin
        acc_r <= nqr_pkg::clamp_wide(fin_sum);
      end
      nqr_pkg::DP_SAVE_DF: begin
        dfx_r <= acc_r;
      end
      nqr_pkg::DP_DIV_INIT: begin
        ud_r   <= dfmag[nqr_pkg::MAG_W-1:0];
        rem_r  <= '0;
        quo_r  <= {amag[nqr_pkg::MAG_W-1:0], {nqr_pkg::FRAC_BITS{1'b0}}};
        cnt_r  <= nqr_pkg::DCNT_W'(nqr_pkg::DIV_W);
        qneg_r <= acc_r[63] ^ dfx_r[63];
      end
      nqr_pkg::DP_DIV_STEP: begin
        rem_r <= q_bit ? nqr_pkg::MAG_W'(rem_sh - {1'b0, ud_r})
                       : rem_sh[nqr_pkg::MAG_W-1:0];
        quo_r <= {quo_r[nqr_pkg::DIV_W-2:0], q_bit};
        cnt_r <= cnt_r - 1'b1;
      end
      nqr_pkg::DP_UPDATE: begin
        if (xs > (nqr_pkg::Q_W + 2)'(32'sh7FFF_FFFF)) begin
          x_r <= 32'sh7FFF_FFFF;
        end else if (xs < -(nqr_pkg::Q_W + 2)'(33'sh0_8000_0000)) begin
          x_r <= 32'sh8000_0000;
        end else begin
          x_r <= xs[31:0];
        end
        k_r <= k_r + 1'b1;
      end
      nqr_pkg::DP_OUT: begin
        out_r.root_estimate   <= (cmd.code == nqr_pkg::ST_ZERO_DERIV ||
                                  cmd.code == nqr_pkg::ST_LEFT_INTERVAL) ? '0 : x_r;
        out_r.status          <= cmd.code;
        out_r.iterations_done <= k_r;
        out_r.final_error     <= err_r;
      end
      default: ;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat.loop_cond    = (err_r > tol_r) || (k_r < min_r);
    stat.cap_hit      = k_r >= max_r;
    stat.zero_deriv   = (acc_r == '0) || (amag < 64'(tol_r));
    stat.out_of_range = (x_r < lo_r) || (x_r > hi_r);
    stat.div_last     = cnt_r == nqr_pkg::DCNT_W'(1);
  end

  assign out_data = out_r;

endmodule

[hdl/nqr_controller.sv]
// ----------------------------------------------------------------------------
// nqr_controller: sequencer of the quartic root finder
// Walks one item through the loop test, the derivative and function
// evaluation, the division and the update, and owns both handshakes.
// ----------------------------------------------------------------------------
module nqr_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nqr_pkg::dp_stat_t stat,
  output nqr_pkg::dp_cmd_t  cmd
);

  nqr_pkg::state_t  state_r, state_nxt;
  nqr_pkg::status_t code_r, code_nxt;
  logic             is_f_r, is_f_nxt;
  logic [1:0]       mstep_r, mstep_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  // State and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nqr_pkg::S_IDLE;
      code_r      <= nqr_pkg::ST_CONVERGED;
      is_f_r      <= 1'b0;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      is_f_r      <= is_f_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    is_f_nxt      = is_f_r;
    mstep_nxt     = mstep_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      nqr_pkg::S_IDLE: begin
        if (in_valid) state_nxt = nqr_pkg::S_ERR;
      end
      nqr_pkg::S_ERR: state_nxt = nqr_pkg::S_CHECK;
      nqr_pkg::S_CHECK: begin
        priority if (!stat.loop_cond) begin
          code_nxt  = nqr_pkg::ST_CONVERGED;
          state_nxt = nqr_pkg::S_FINISH;
        end else if (stat.cap_hit) begin
          code_nxt  = nqr_pkg::ST_ITER_CAP;
          state_nxt = nqr_pkg::S_FINISH;
        end else begin
          state_nxt = nqr_pkg::S_DF_INIT;
        end
      end
      nqr_pkg::S_DF_INIT: begin
        is_f_nxt  = 1'b0;
        mstep_nxt = '0;
        state_nxt = nqr_pkg::S_MUL_LO;
      end
      nqr_pkg::S_MUL_LO: state_nxt = nqr_pkg::S_MUL_HI;
      nqr_pkg::S_MUL_HI: state_nxt = nqr_pkg::S_MUL_FIN;
      nqr_pkg::S_MUL_FIN: begin
        // The derivative takes two Horner products, the function three.
        if (!is_f_r && mstep_r == 2'd1) begin
          state_nxt = nqr_pkg::S_DERIV_CHK;
        end else if (is_f_r && mstep_r == 2'd2) begin
          state_nxt = nqr_pkg::S_DIV_INIT;
        end else begin
          mstep_nxt = mstep_r + 1'b1;
          state_nxt = nqr_pkg::S_MUL_LO;
        end
      end
      nqr_pkg::S_DERIV_CHK: begin
        priority if (stat.zero_deriv) begin
          code_nxt  = nqr_pkg::ST_ZERO_DERIV;
          state_nxt = nqr_pkg::S_FINISH;
        end else if (stat.out_of_range) begin
          code_nxt  = nqr_pkg::ST_LEFT_INTERVAL;
          state_nxt = nqr_pkg::S_FINISH;
        end else begin
          state_nxt = nqr_pkg::S_F_INIT;
        end
      end
      nqr_pkg::S_F_INIT: begin
        is_f_nxt  = 1'b1;
        mstep_nxt = '0;
        state_nxt = nqr_pkg::S_MUL_LO;
      end
      nqr_pkg::S_DIV_INIT: state_nxt = nqr_pkg::S_DIV_STEP;
      nqr_pkg::S_DIV_STEP: begin
        if (stat.div_last) state_nxt = nqr_pkg::S_UPDATE;
      end
      nqr_pkg::S_UPDATE: state_nxt = nqr_pkg::S_ERR;
      nqr_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = nqr_pkg::S_IDLE;
        end
      end
      default: state_nxt = nqr_pkg::S_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd.op      = nqr_pkg::DP_NOP;
    cmd.code    = code_r;
    cmd.cst_sel = nqr_pkg::HC_P22;
    unique case ({is_f_r, mstep_r})
      3'b000:  cmd.cst_sel = nqr_pkg::HC_P22;
      3'b001:  cmd.cst_sel = nqr_pkg::HC_P29;
      3'b100:  cmd.cst_sel = nqr_pkg::HC_P11;
      3'b101:  cmd.cst_sel = nqr_pkg::HC_P29;
      3'b110:  cmd.cst_sel = nqr_pkg::HC_M10;
      default: cmd.cst_sel = nqr_pkg::HC_P22;
    endcase
    unique case (state_r)
      nqr_pkg::S_IDLE:      if (in_valid) cmd.op = nqr_pkg::DP_LOAD;
      nqr_pkg::S_ERR:       cmd.op = nqr_pkg::DP_ERR;
      nqr_pkg::S_DF_INIT:   cmd.op = nqr_pkg::DP_DF_INIT;
      nqr_pkg::S_F_INIT:    cmd.op = nqr_pkg::DP_F_INIT;
      nqr_pkg::S_MUL_LO:    cmd.op = nqr_pkg::DP_MUL_LO;
      nqr_pkg::S_MUL_HI:    cmd.op = nqr_pkg::DP_MUL_HI;
      nqr_pkg::S_MUL_FIN:   cmd.op = nqr_pkg::DP_MUL_FIN;
      nqr_pkg::S_DERIV_CHK: cmd.op = nqr_pkg::DP_SAVE_DF;
      nqr_pkg::S_DIV_INIT:  cmd.op = nqr_pkg::DP_DIV_INIT;
      nqr_pkg::S_DIV_STEP:  cmd.op = nqr_pkg::DP_DIV_STEP;
      nqr_pkg::S_UPDATE:    cmd.op = nqr_pkg::DP_UPDATE;
      nqr_pkg::S_FINISH:    if (out_free) cmd.op = nqr_pkg::DP_OUT;
      default:              cmd.op = nqr_pkg::DP_NOP;
    endcase
  end

  assign in_ready  = state_r == nqr_pkg::S_IDLE;
  assign out_valid = out_valid_r;

endmodule

[hdl/newton_quartic_root_finder.sv]
// ----------------------------------------------------------------------------
// newton_quartic_root_finder: Newton-Raphson root search on a fixed quartic
// Iterates x <- x - f(x)/f'(x) for f = 21x^4+29x^3+11x^2+29x-10 in Q8.24,
// starting at the midpoint of the given interval.
// ----------------------------------------------------------------------------
// One item is worked at a time. Each Newton update (counted in
// iterations_done) runs the bit-serial divider that forms f(x)/f'(x) and
// five Horner products, each a low-half pass, a high-half pass and a
// finishing step on one shared 32x32 multiplier, plus control steps. A
// finished result waits in its own register, so the next beat is accepted
// as soon as the sequencer is idle.
module newton_quartic_root_finder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nqr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nqr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);

  nqr_pkg::dp_cmd_t  cmd;
  nqr_pkg::dp_stat_t stat;

  // Sequencer.
  nqr_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and registers.
  nqr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

[hdl/nqr_checker.sv]
// ----------------------------------------------------------------------------
// nqr_port_checks: port-level checks of the quartic root finder
// Watches the handshakes and result fields and is bound to the top level.
// ----------------------------------------------------------------------------
module nqr_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input nqr_pkg::out_item_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // An error status always carries a zero root.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == nqr_pkg::ST_ZERO_DERIV ||
                  out_data.status == nqr_pkg::ST_LEFT_INTERVAL)
    |-> out_data.root_estimate == '0)
    else $error("error status with nonzero root");

  // After an accepted input beat the block is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind newton_quartic_root_finder nqr_port_checks u_chk (.*);
